>>> sv/dds_pkg.sv
// Package for the descending distance sorter: widths, cell entry and command types,
// and the controller state type. No dependencies.
package dds_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int KEY_W       = 16;
   localparam int TAG_W       = 10;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 32;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] new_key;
      logic [TAG_W-1:0] new_tag;
   } cell_cmd_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

>>> sv/descending_distance_sorter_top.sv
// Top level of the descending distance sorter: controller and a chain of dds_cell.
// Depends on dds_pkg and dds_cell.
//
//  channel | dir | tdata (low bit up)                 | tlast       | tuser
//  req_    | in  | distance[15:0], tag[25:16], pad    | end_of_run  | -
//  rsp_    | out | sorted_distance[15:0], sorted_tag  | last_result | dropped
//
// Load: one word a cycle; every cell compares in parallel and the chain
// opens a gap in one step, so words may arrive back to back.
// Drain: after the word marked last, the chain shifts towards the head, one
// result per cycle; no input is taken then.
// A stalled rsp_tready simply freezes the chain. Reset is synchronous and
// clears the cell valid bits, the state and the dropped flag.
module descending_distance_sorter_top
   import dds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // distance[15:0], tag[25:16], zero pad
   input  logic                  req_tlast,  // end_of_run
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // sorted_distance[15:0], sorted_tag[25:16]
   output logic                  rsp_tlast,  // last_result
   output logic                  rsp_tuser   // dropped
);

   state_type    state_ff, state_in;
   logic         dropped_ff, dropped_in;
   cell_cmd_type cmd;

   entry_type ent [0:MAX_ENTRIES];
   logic      keep_chain [0:MAX_ENTRIES];

   logic req_fire, rsp_fire, full, final_word;

   assign ent[MAX_ENTRIES] = '0;   // beyond the tail: empty
   assign keep_chain[0]    = 1'b1; // head: newcomer enters cell 0 if it beats it

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         entry_type prev_e;
         if (gi == 0) begin : g_head
            assign prev_e = '0;
         end else begin : g_body
            assign prev_e = ent[gi-1];
         end
         dds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_keep  (keep_chain[gi]),
            .prev_entry (prev_e),
            .next_entry (ent[gi+1]),
            .entry      (ent[gi]),
            .keep       (keep_chain[gi+1])
         );
      end
   endgenerate

   assign full       = ent[MAX_ENTRIES-1].valid;
   assign final_word = !ent[1].valid;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in    = state_ff;
      dropped_in  = dropped_ff;
      cmd.op      = CELL_HOLD;
      cmd.new_key = req_tdata[KEY_W-1:0];
      cmd.new_tag = req_tdata[KEY_W+TAG_W-1:KEY_W];
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;   // no room: word discarded
               end else begin
                  cmd.op = CELL_INSERT;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_tvalid = ent[0].valid;
            if (rsp_fire) begin
               cmd.op = CELL_SHIFT;
               if (final_word) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-KEY_W-TAG_W){1'b0}}, ent[0].tag, ent[0].key};
   assign rsp_tlast = final_word;
   assign rsp_tuser = dropped_ff;

endmodule

>>> sv/dds_cell.sv
// One cell of the insertion chain: holds a single entry and its valid bit.
// Depends on dds_pkg.
module dds_cell
   import dds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic         prev_keep,   // upstream cell keeps its entry (or chain head)
   input  entry_type    prev_entry,  // upstream neighbour's entry
   input  entry_type    next_entry,  // downstream neighbour's entry, used on drain
   output entry_type    entry,
   output logic         keep
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // stable order: an equal stored key stays ahead of the newcomer
   assign keep = valid_ff && (key_ff >= cmd.new_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (prev_keep) begin
                  valid_in = 1'b1;
                  key_in   = cmd.new_key;
                  tag_in   = cmd.new_tag;
               end else begin
                  valid_in = prev_entry.valid;
                  key_in   = prev_entry.key;
                  tag_in   = prev_entry.tag;
               end
            end
         end
         CELL_SHIFT: begin
            valid_in = next_entry.valid;
            key_in   = next_entry.key;
            tag_in   = next_entry.tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.tag   = tag_ff;

endmodule
